FILE: rtl/csvtok_pkg.sv
package csvtok_pkg;

   // Character codes that steer the parse.
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE      = 2'd0;
   localparam logic [1:0] KIND_FIELD_END = 2'd1;
   localparam logic [1:0] KIND_ERROR     = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_EMPTY_HEADER = 3'd1;
   localparam logic [2:0] ERR_MISMATCH     = 3'd2;
   localparam logic [2:0] ERR_TOO_MANY     = 3'd3;
   localparam logic [2:0] ERR_WS_OVERFLOW  = 3'd4;
   localparam logic [2:0] ERR_UNCLOSED     = 3'd5;

   // Entries in the queue between classifier and executor.
   localparam int QUEUE_DEPTH = 4;

   // Action that the classifier asks of the executor for one item.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_SPACE,
      OP_DATA,
      OP_FIELD_END,
      OP_ROW_END
   } op_type;

   // One classified item.
   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       end_of_text;
      logic       unclosed;
   } token_type;

   // Whitespace that is trimmed or held back: space, tab, CR and LF.
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

FILE: rtl/csvtok_front.sv
module csvtok_front
   import csvtok_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   input  logic       q_full,
   output logic       q_push,
   output token_type  q_token
);

   logic       inside_quotes_ff, inside_quotes_in;
   logic       quote_pending_ff, quote_pending_in;
   logic       skip_lf_ff, skip_lf_in;
   logic [7:0] cur_byte;
   logic       handled;
   token_type  tok;

   // The input waits only while the queue is full.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_token   = tok;

   // Quote and line-end handling; classifies the item for the executor.
   always_comb begin
      inside_quotes_in = inside_quotes_ff;
      quote_pending_in = quote_pending_ff;
      skip_lf_in       = skip_lf_ff;
      cur_byte         = req_data_byte;
      handled          = 1'b0;
      tok.op           = OP_NONE;
      tok.data_byte    = req_data_byte;
      tok.end_of_text  = req_end_of_text;
      tok.unclosed     = 1'b0;

      // An LF right after a CR was already turned into a line end.
      if (skip_lf_ff) begin
         skip_lf_in = 1'b0;
         if (req_data_byte == CH_LF) begin
            handled = 1'b1;
         end
      end

      // A quote inside a quoted run is either doubled or closes the run.
      if (!handled && quote_pending_ff) begin
         quote_pending_in = 1'b0;
         if (req_data_byte == CH_QUOTE) begin
            tok.op        = OP_DATA;
            tok.data_byte = CH_QUOTE;
            handled       = 1'b1;
         end else begin
            inside_quotes_in = 1'b0;
         end
      end

      if (!handled) begin
         if (req_data_byte == CH_CR) begin
            cur_byte   = CH_LF;
            skip_lf_in = 1'b1;
         end
         if (cur_byte == CH_QUOTE) begin
            if (!inside_quotes_in) begin
               inside_quotes_in = 1'b1;
            end else begin
               quote_pending_in = 1'b1;
            end
         end else if (!inside_quotes_in && cur_byte == CH_COMMA) begin
            tok.op = OP_FIELD_END;
         end else if (!inside_quotes_in && cur_byte == CH_LF) begin
            tok.op = OP_ROW_END;
         end else begin
            tok.data_byte = cur_byte;
            tok.op        = is_space(cur_byte) ? OP_SPACE : OP_DATA;
         end
      end

      // A pending quote closes the run at the end of the text.
      tok.unclosed = inside_quotes_in && !quote_pending_in;

      if (req_end_of_text) begin
         inside_quotes_in = 1'b0;
         quote_pending_in = 1'b0;
         skip_lf_in       = 1'b0;
      end
   end

   // Parse state advances on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_quotes_ff <= 1'b0;
         quote_pending_ff <= 1'b0;
         skip_lf_ff       <= 1'b0;
      end else if (q_push) begin
         inside_quotes_ff <= inside_quotes_in;
         quote_pending_ff <= quote_pending_in;
         skip_lf_ff       <= skip_lf_in;
      end
   end

endmodule

FILE: rtl/csvtok_queue.sv
module csvtok_queue
   import csvtok_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output token_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

   token_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full   = (count_ff == FULL_COUNT);
   assign empty  = (count_ff == '0);
   assign head   = entry_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

FILE: rtl/csvtok_back.sv
module csvtok_back
   import csvtok_pkg::*;
#(
   parameter int MAX_COLUMNS   = 64,
   parameter int WS_HOLD_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  token_type  q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_field_byte,
   output logic [5:0] rsp_column_index,
   output logic       rsp_in_header,
   output logic       rsp_row_end,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   localparam int COL_W = $clog2(MAX_COLUMNS + 1);
   localparam int HC_W  = $clog2(WS_HOLD_DEPTH + 1);
   localparam int IDX_W = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
   localparam logic [COL_W:0]  MAX_COL_C = (COL_W + 1)'(MAX_COLUMNS);
   localparam logic [HC_W-1:0] HOLD_FULL = HC_W'(WS_HOLD_DEPTH);

   typedef enum logic [1:0] {
      ST_OP,
      ST_FIN,
      ST_REL_READ,
      ST_REL_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic             sticky_ff, sticky_in;
   logic             header_done_ff, header_done_in;
   logic [COL_W-1:0] header_cols_ff, header_cols_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic             has_content_ff, has_content_in;
   logic [HC_W-1:0]  held_count_ff, held_count_in;
   logic [IDX_W-1:0] rel_idx_ff, rel_idx_in;
   logic [7:0]       rd_data_ff;
   logic [7:0]       held_mem [WS_HOLD_DEPTH];
   logic             mem_we;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [5:0]       rsp_column_ff, rsp_column_in;
   logic             rsp_header_ff, rsp_header_in;
   logic             rsp_row_end_ff, rsp_row_end_in;
   logic [2:0]       rsp_code_ff, rsp_code_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             em_valid;
   logic [1:0]       em_kind;
   logic [7:0]       em_byte;
   logic [2:0]       em_code;
   logic             em_row_end;
   logic             em_last;

   logic [COL_W:0]   col_p1;
   logic             row_empty;
   logic [2:0]       re_code;
   logic             fin_cond;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Outcome of ending the current row.
   always_comb begin
      col_p1    = {1'b0, column_ff} + 1'b1;
      row_empty = (column_ff == '0) && !has_content_ff;
      fin_cond  = !header_done_ff || (column_ff != '0) || has_content_ff;
      re_code   = ERR_NONE;
      if (!header_done_ff && row_empty) begin
         re_code = ERR_EMPTY_HEADER;
      end else if (header_done_ff && !row_empty && col_p1 != {1'b0, header_cols_ff}) begin
         re_code = ERR_MISMATCH;
      end
   end

   // Executor: one action per cycle, waiting while a result is stalled; held whitespace released a byte at a time.
   always_comb begin
      state_in       = state_ff;
      sticky_in      = sticky_ff;
      header_done_in = header_done_ff;
      header_cols_in = header_cols_ff;
      column_in      = column_ff;
      has_content_in = has_content_ff;
      held_count_in  = held_count_ff;
      rel_idx_in     = rel_idx_ff;
      q_pop          = 1'b0;
      mem_we         = 1'b0;
      em_valid       = 1'b0;
      em_kind        = KIND_BYTE;
      em_byte        = '0;
      em_code        = ERR_NONE;
      em_row_end     = 1'b0;
      em_last        = 1'b0;

      case (state_ff)
         ST_OP: begin
            if (!q_empty) begin
               if (sticky_ff) begin
                  // After an error every item is dropped.
                  q_pop = 1'b1;
               end else begin
                  case (q_head.op)
                     OP_NONE: begin
                        if (q_head.end_of_text) begin
                           state_in = ST_FIN;
                        end else begin
                           q_pop = 1'b1;
                        end
                     end
                     OP_SPACE: begin
                        if (has_content_ff && held_count_ff >= HOLD_FULL) begin
                           if (out_free) begin
                              em_valid  = 1'b1;
                              em_kind   = KIND_ERROR;
                              em_code   = ERR_WS_OVERFLOW;
                              em_last   = 1'b1;
                              sticky_in = 1'b1;
                              q_pop     = 1'b1;
                           end
                        end else begin
                           if (has_content_ff) begin
                              mem_we        = 1'b1;
                              held_count_in = held_count_ff + 1'b1;
                           end
                           if (q_head.end_of_text) begin
                              state_in = ST_FIN;
                           end else begin
                              q_pop = 1'b1;
                           end
                        end
                     end
                     OP_DATA: begin
                        if (held_count_ff != '0) begin
                           rel_idx_in = '0;
                           state_in   = ST_REL_READ;
                        end else if (out_free) begin
                           em_valid       = 1'b1;
                           em_kind        = KIND_BYTE;
                           em_byte        = q_head.data_byte;
                           em_last        = !q_head.end_of_text;
                           has_content_in = 1'b1;
                           if (q_head.end_of_text) begin
                              state_in = ST_FIN;
                           end else begin
                              q_pop = 1'b1;
                           end
                        end
                     end
                     OP_FIELD_END: begin
                        if (out_free) begin
                           em_valid = 1'b1;
                           if (col_p1 >= MAX_COL_C) begin
                              em_kind   = KIND_ERROR;
                              em_code   = ERR_TOO_MANY;
                              em_last   = 1'b1;
                              sticky_in = 1'b1;
                              q_pop     = 1'b1;
                           end else begin
                              em_kind        = KIND_FIELD_END;
                              em_last        = !q_head.end_of_text;
                              has_content_in = 1'b0;
                              held_count_in  = '0;
                              column_in      = col_p1[COL_W-1:0];
                              if (q_head.end_of_text) begin
                                 state_in = ST_FIN;
                              end else begin
                                 q_pop = 1'b1;
                              end
                           end
                        end
                     end
                     OP_ROW_END: begin
                        if (out_free) begin
                           if (re_code != ERR_NONE) begin
                              em_valid  = 1'b1;
                              em_kind   = KIND_ERROR;
                              em_code   = re_code;
                              em_last   = 1'b1;
                              sticky_in = 1'b1;
                              q_pop     = 1'b1;
                           end else begin
                              // An empty data row ends silently.
                              em_valid   = !header_done_ff || !row_empty;
                              em_kind    = KIND_FIELD_END;
                              em_row_end = 1'b1;
                              em_last    = !(q_head.end_of_text && q_head.unclosed);
                              if (!header_done_ff) begin
                                 header_cols_in = col_p1[COL_W-1:0];
                                 header_done_in = 1'b1;
                              end
                              has_content_in = 1'b0;
                              held_count_in  = '0;
                              column_in      = '0;
                              if (q_head.end_of_text) begin
                                 state_in = ST_FIN;
                              end else begin
                                 q_pop = 1'b1;
                              end
                           end
                        end
                     end
                     default: begin
                        q_pop = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_FIN: begin
            // End of text: flag an open quote, or close the unfinished row and clear the header state.
            if (q_head.unclosed) begin
               if (out_free) begin
                  em_valid  = 1'b1;
                  em_kind   = KIND_ERROR;
                  em_code   = ERR_UNCLOSED;
                  em_last   = 1'b1;
                  sticky_in = 1'b1;
                  q_pop     = 1'b1;
                  state_in  = ST_OP;
               end
            end else if (!fin_cond || out_free) begin
               if (fin_cond) begin
                  em_valid = 1'b1;
                  em_last  = 1'b1;
                  if (re_code != ERR_NONE) begin
                     em_kind   = KIND_ERROR;
                     em_code   = re_code;
                     sticky_in = 1'b1;
                  end else begin
                     em_kind    = KIND_FIELD_END;
                     em_row_end = 1'b1;
                  end
               end
               header_done_in = 1'b0;
               header_cols_in = '0;
               column_in      = '0;
               has_content_in = 1'b0;
               held_count_in  = '0;
               q_pop          = 1'b1;
               state_in       = ST_OP;
            end
         end
         ST_REL_READ: begin
            state_in = ST_REL_EMIT;
         end
         ST_REL_EMIT: begin
            if (out_free) begin
               em_valid = 1'b1;
               em_kind  = KIND_BYTE;
               em_byte  = rd_data_ff;
               if (HC_W'(rel_idx_ff) + 1'b1 == held_count_ff) begin
                  // The content byte itself goes out from ST_OP.
                  held_count_in = '0;
                  state_in      = ST_OP;
               end else begin
                  rel_idx_in = rel_idx_ff + 1'b1;
                  state_in   = ST_REL_READ;
               end
            end
         end
         default: begin
            state_in = ST_OP;
         end
      endcase
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in   = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_column_in  = rsp_column_ff;
      rsp_header_in  = rsp_header_ff;
      rsp_row_end_in = rsp_row_end_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_last_in    = rsp_last_ff;
      if (em_valid) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = em_kind;
         rsp_byte_in    = em_byte;
         rsp_column_in  = 6'(column_ff);
         rsp_header_in  = !header_done_ff;
         rsp_row_end_in = em_row_end;
         rsp_code_in    = em_code;
         rsp_last_in    = em_last;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_OP;
         sticky_ff      <= 1'b0;
         header_done_ff <= 1'b0;
         header_cols_ff <= '0;
         column_ff      <= '0;
         has_content_ff <= 1'b0;
         held_count_ff  <= '0;
         rel_idx_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sticky_ff      <= sticky_in;
         header_done_ff <= header_done_in;
         header_cols_ff <= header_cols_in;
         column_ff      <= column_in;
         has_content_ff <= has_content_in;
         held_count_ff  <= held_count_in;
         rel_idx_ff     <= rel_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_kind_ff    <= rsp_kind_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_column_ff  <= rsp_column_in;
      rsp_header_ff  <= rsp_header_in;
      rsp_row_end_ff <= rsp_row_end_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Held whitespace store with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         held_mem[held_count_ff[IDX_W-1:0]] <= q_head.data_byte;
      end
      if (state_ff == ST_REL_READ) begin
         rd_data_ff <= held_mem[rel_idx_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_field_byte   = rsp_byte_ff;
   assign rsp_column_index = rsp_column_ff;
   assign rsp_in_header    = rsp_header_ff;
   assign rsp_row_end      = rsp_row_end_ff;
   assign rsp_error_code   = rsp_code_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      sticky_ff |=> sticky_ff)
      else $error("Error state was left without a reset.");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_ERROR) |-> rsp_last_ff)
      else $error("An error report was not the final result of its item.");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      col_p1 <= MAX_COL_C)
      else $error("Column counter passed the column limit.");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= HOLD_FULL)
      else $error("Held whitespace count passed the store depth.");
`endif

endmodule

FILE: rtl/csv_stream_tokenizer_top.sv
// CSV tokenizer: takes one byte of text per item and returns field bytes, field ends with
// their column and row-end flag, and error reports. A classifier resolves quotes and line
// ends as each byte arrives and passes one action per byte through a four-entry queue to an
// executor that tracks columns, the header and held-back whitespace, and owns the result
// register. For plain bytes, separators and line ends the block keeps pace at one byte per
// cycle while the result register is not stalled; the byte that ends the text also passes
// through the ST_FIN state, and a content byte that releases held whitespace first sends out
// each released byte, since the whitespace store is read one registered entry at a time.
// Each accepted byte is registered in the queue, and its results in the result register.
// After an error report the block drops all input until reset. No clearing pass is needed
// after reset.
module csv_stream_tokenizer_top
   import csvtok_pkg::*;
#(
   parameter int MAX_COLUMNS   = 64,
   parameter int WS_HOLD_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_field_byte,
   output logic [5:0] rsp_column_index,
   output logic       rsp_in_header,
   output logic       rsp_row_end,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_empty;
   token_type push_token;
   token_type head_token;

   // Classifier.
   csvtok_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_token         (push_token)
   );

   // Action queue.
   csvtok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (head_token)
   );

   // Executor and result register.
   csvtok_back #(
      .MAX_COLUMNS   (MAX_COLUMNS),
      .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (head_token),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_field_byte   (rsp_field_byte),
      .rsp_column_index (rsp_column_index),
      .rsp_in_header    (rsp_in_header),
      .rsp_row_end      (rsp_row_end),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: verif/csv_stream_tokenizer_checker.sv
`timescale 1ns / 1ps
module csv_stream_tokenizer_checker
   import csvtok_pkg::*;
#(
   parameter int MAX_COLUMNS   = 64,
   parameter int WS_HOLD_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_field_byte,
   input  logic [5:0] rsp_column_index,
   input  logic       rsp_in_header,
   input  logic       rsp_row_end,
   input  logic [2:0] rsp_error_code,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending_count
);

   // One token that the tokenizer is expected to return.
   typedef struct {
      logic [1:0] kind;
      logic [7:0] field_byte;
      logic [5:0] column_index;
      logic       in_header;
      logic       row_end;
      logic [2:0] error_code;
      logic       last;
   } result_type;

   result_type expected_tokens[$];

   // Parser state mirrored from the block.
   logic       in_quotes;
   logic       quote_seen;
   logic       drop_lf;
   logic       has_content;
   logic       header_seen;
   logic       halted;
   logic [7:0] held_ws[WS_HOLD_DEPTH];
   int         held_n;
   int         column;
   int         header_cols;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   task automatic push_token(input logic [1:0] k, input logic [7:0] b, input logic [2:0] code,
                             input logic rend);
      result_type t;
      t.kind         = k;
      t.field_byte   = b;
      t.column_index = column[5:0];
      t.in_header    = !header_seen;
      t.row_end      = rend;
      t.error_code   = code;
      t.last         = 1'b0;
      expected_tokens = {expected_tokens, t};
   endtask

   // An error report ends all output until the next reset.
   task automatic raise_fault(input logic [2:0] code);
      push_token(KIND_ERROR, 8'h00, code, 1'b0);
      halted = 1'b1;
   endtask

   // Leading whitespace is dropped; trailing whitespace waits for more content.
   task automatic add_content(input logic [7:0] c);
      if (is_ws(c)) begin
         if (has_content) begin
            if (held_n >= WS_HOLD_DEPTH) begin
               raise_fault(ERR_WS_OVERFLOW);
            end else begin
               held_ws[held_n] = c;
               held_n++;
            end
         end
      end else begin
         for (int i = 0; i < held_n; i++) begin
            push_token(KIND_BYTE, held_ws[i], ERR_NONE, 1'b0);
         end
         held_n = 0;
         push_token(KIND_BYTE, c, ERR_NONE, 1'b0);
         has_content = 1'b1;
      end
   endtask

   task automatic close_field();
      if (column + 1 >= MAX_COLUMNS) begin
         raise_fault(ERR_TOO_MANY);
      end else begin
         push_token(KIND_FIELD_END, 8'h00, ERR_NONE, 1'b0);
         held_n      = 0;
         has_content = 1'b0;
         column++;
      end
   endtask

   // The first row fixes the column count; blank data rows are dropped.
   task automatic close_row();
      logic blank;
      blank = (column == 0) && !has_content;
      if (!header_seen) begin
         if (blank) begin
            raise_fault(ERR_EMPTY_HEADER);
            return;
         end
         push_token(KIND_FIELD_END, 8'h00, ERR_NONE, 1'b1);
         header_cols = column + 1;
         header_seen = 1'b1;
      end else if (!blank) begin
         if (column + 1 != header_cols) begin
            raise_fault(ERR_MISMATCH);
            return;
         end
         push_token(KIND_FIELD_END, 8'h00, ERR_NONE, 1'b1);
      end
      held_n      = 0;
      has_content = 1'b0;
      column      = 0;
   endtask

   // Line-end folding and quote handling ahead of the field logic.
   task automatic parse_byte(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (drop_lf) begin
         drop_lf = 1'b0;
         if (c == CH_LF) return;
      end
      if (quote_seen) begin
         quote_seen = 1'b0;
         if (c == CH_QUOTE) begin
            add_content(CH_QUOTE);
            return;
         end
         in_quotes = 1'b0;
      end
      if (c == CH_CR) begin
         c       = CH_LF;
         drop_lf = 1'b1;
      end
      if (c == CH_QUOTE) begin
         if (!in_quotes) in_quotes = 1'b1;
         else quote_seen = 1'b1;
      end else if (!in_quotes && c == CH_COMMA) begin
         close_field();
      end else if (!in_quotes && c == CH_LF) begin
         close_row();
      end else begin
         add_content(c);
      end
   endtask

   task automatic wrap_up_text();
      if (quote_seen) begin
         quote_seen = 1'b0;
         in_quotes  = 1'b0;
      end
      if (in_quotes) begin
         raise_fault(ERR_UNCLOSED);
      end else if (!header_seen || column != 0 || has_content) begin
         close_row();
      end
   endtask

   task automatic restart_text();
      in_quotes   = 1'b0;
      quote_seen  = 1'b0;
      drop_lf     = 1'b0;
      has_content = 1'b0;
      held_n      = 0;
      column      = 0;
      header_cols = 0;
      header_seen = 1'b0;
   endtask

   // Works out every token that one accepted byte causes.
   task automatic tokenize_byte(input logic [7:0] b, input logic eot);
      int start_count;
      start_count = expected_tokens.size();
      if (halted) return;
      parse_byte(b);
      if (eot && !halted) wrap_up_text();
      if (eot) restart_text();
      // The final token of this byte carries the last flag.
      if (expected_tokens.size() > start_count) begin
         expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      end
   endtask

   task automatic match_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_token();
      result_type want;
      if (expected_tokens.size() == 0) begin
         $error("unexpected result: kind %0d, byte %0h, column %0d, error %0d",
                rsp_kind, rsp_field_byte, rsp_column_index, rsp_error_code);
         fail_count++;
         return;
      end
      want = expected_tokens.pop_front();
      match_field("kind", 8'(want.kind), 8'(rsp_kind));
      match_field("field_byte", want.field_byte, rsp_field_byte);
      match_field("column_index", 8'(want.column_index), 8'(rsp_column_index));
      match_field("in_header", 8'(want.in_header), 8'(rsp_in_header));
      match_field("row_end", 8'(want.row_end), 8'(rsp_row_end));
      match_field("error_code", 8'(want.error_code), 8'(rsp_error_code));
      match_field("last", 8'(want.last), 8'(rsp_last));
   endtask

   // Both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         restart_text();
         halted     = 1'b0;
         fail_count = 0;
         expected_tokens.delete();
      end else begin
         if (req_valid && !req_stall) tokenize_byte(req_data_byte, req_end_of_text);
         if (rsp_valid && !rsp_stall) check_token();
      end
      pending_count = expected_tokens.size();
   end

endmodule

FILE: verif/tb_csv_stream_tokenizer_top.sv
`timescale 1ns / 1ps
module tb_csv_stream_tokenizer_top;
   import csvtok_pkg::*;

   localparam int HALF_PERIOD      = 6;
   localparam int CLOCK_PERIOD     = 2 * HALF_PERIOD;
   localparam int RESET_CYCLES     = 7;
   localparam int TARGET_ITEMS     = 420;
   localparam int WATCHDOG_CYCLES  = 3_000_000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int MAX_COLUMNS_TB   = 64;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_field_byte;
   logic [5:0] rsp_column_index;
   logic       rsp_in_header;
   logic       rsp_row_end;
   logic [2:0] rsp_error_code;
   logic       rsp_last;
   int         fail_count;
   int         pending_count;

   // Bytes of the text being built, and how many items went in so far.
   logic [7:0] text_buf[$];
   int         items_sent = 0;
   bit         calm = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   csv_stream_tokenizer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_field_byte  (rsp_field_byte),
      .rsp_column_index(rsp_column_index),
      .rsp_in_header   (rsp_in_header),
      .rsp_row_end     (rsp_row_end),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last)
   );

   csv_stream_tokenizer_checker token_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_field_byte  (rsp_field_byte),
      .rsp_column_index(rsp_column_index),
      .rsp_in_header   (rsp_in_header),
      .rsp_row_end     (rsp_row_end),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // A content byte that is neither a separator, a quote nor whitespace.
   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF ||
                 c == CH_SPACE || c == CH_TAB);
      return c;
   endfunction

   // The receiver stalls in bursts, except while a calm stretch runs.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // Offers one item at the falling edge and holds it until it is taken.
   task automatic send_byte(input logic [7:0] b, input logic eot);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) begin
         send_byte(text_buf[i], i == text_buf.size() - 1);
      end
      text_buf.delete();
   endtask

   // Holds the sender back until every expected token has come out.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // Appends one byte to the text being built.
   task automatic add_byte(input logic [7:0] b);
      text_buf = {text_buf, b};
   endtask

   task automatic add_ws_run(input int n);
      repeat (n) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   task automatic add_plain_run(input int n);
      repeat (n) add_byte(pick_plain());
   endtask

   // A quoted run holding separators, line ends, spaces and doubled quotes.
   task automatic add_quoted();
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 6))
            0: add_byte(CH_COMMA);
            1: add_byte(CH_LF);
            2: add_byte(CH_CR);
            3: begin
               add_byte(CH_CR);
               add_byte(CH_LF);
            end
            4: begin
               add_byte(CH_QUOTE);
               add_byte(CH_QUOTE);
            end
            5: add_byte(CH_SPACE);
            default: add_byte(pick_plain());
         endcase
      end
      add_byte(CH_QUOTE);
   endtask

   // A quoted run is never followed by a quote, so it always closes.
   task automatic add_field(input bit must_fill);
      bit after_quote;
      after_quote = 1'b0;
      if (must_fill) add_plain_run($urandom_range(1, 3));
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(after_quote ? 0 : 0, after_quote ? 1 : 2))
            0: begin
               add_ws_run($urandom_range(1, 3));
               after_quote = 1'b0;
            end
            1: begin
               add_plain_run($urandom_range(1, 4));
               after_quote = 1'b0;
            end
            default: begin
               add_quoted();
               after_quote = 1'b1;
            end
         endcase
      end
   endtask

   task automatic add_row_end();
      case ($urandom_range(0, 2))
         0: add_byte(CH_LF);
         1: add_byte(CH_CR);
         default: begin
            add_byte(CH_CR);
            add_byte(CH_LF);
         end
      endcase
   endtask

   task automatic add_row(input int cols, input bit is_header);
      for (int c = 0; c < cols; c++) begin
         add_field(is_header);
         if (c < cols - 1) add_byte(CH_COMMA);
      end
   endtask

   // A header and a few matching data rows, with blank lines mixed in.
   task automatic build_table();
      int cols;
      int rows;
      cols = $urandom_range(1, 6);
      rows = $urandom_range(0, 4);
      add_row(cols, 1'b1);
      for (int r = 0; r < rows; r++) begin
         add_row_end();
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
               0: ;
               1: add_ws_run($urandom_range(1, 3));
               default: begin
                  add_byte(CH_QUOTE);
                  add_byte(CH_QUOTE);
               end
            endcase
            add_byte(CH_LF);
         end
         add_row(cols, 1'b0);
      end
      if ($urandom_range(0, 1)) add_row_end();
   endtask

   // A header-only line of arbitrary bytes, quotes and line ends excluded.
   task automatic build_noise();
      logic [7:0] c;
      add_byte(pick_plain());
      repeat ($urandom_range(1, 11)) begin
         c = 8'($urandom_range(0, 255));
         if (c == CH_QUOTE || c == CH_CR || c == CH_LF) c = pick_plain();
         add_byte(c);
      end
   endtask

   // The widest header the block allows, then a data row of empty fields.
   task automatic build_wide();
      for (int c = 0; c < MAX_COLUMNS_TB; c++) begin
         add_plain_run(1);
         if (c < MAX_COLUMNS_TB - 1) add_byte(CH_COMMA);
      end
      add_byte(CH_LF);
      repeat (MAX_COLUMNS_TB - 1) add_byte(CH_COMMA);
      add_byte(CH_LF);
   endtask

   // A text that ends the run with the chosen error.
   task automatic build_fault(input logic [2:0] code);
      case (code)
         ERR_EMPTY_HEADER: begin
            add_ws_run($urandom_range(0, 3));
            add_byte(CH_LF);
         end
         ERR_MISMATCH: begin
            add_row(2, 1'b1);
            add_byte(CH_LF);
            add_row(1, 1'b1);
            add_byte(CH_LF);
         end
         ERR_TOO_MANY: begin
            add_plain_run(1);
            repeat (MAX_COLUMNS_TB + 1) add_byte(CH_COMMA);
         end
         ERR_WS_OVERFLOW: begin
            add_plain_run(1);
            add_ws_run(17);
            add_plain_run(1);
         end
         default: begin
            add_byte(CH_QUOTE);
            add_plain_run($urandom_range(1, 3));
         end
      endcase
   endtask

   initial begin
      #(WATCHDOG_CYCLES * CLOCK_PERIOD);
      $display("csv_stream_tokenizer_top: mismatch");
      $finish;
   end

   initial begin
      bit         wide_done;
      logic [2:0] fault;
      wide_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Smallest and largest bytes around a full whitespace store.
      add_byte(8'h00);
      repeat (8) begin
         add_byte(CH_SPACE);
         add_byte(CH_TAB);
      end
      add_byte(8'hFF);
      send_text();

      // Doubled quote, quoted line end, CRLF rows and a quote left pending at the end.
      text_buf = {CH_QUOTE, "q", CH_QUOTE, CH_QUOTE, CH_CR, CH_LF, CH_QUOTE, CH_COMMA, "y",
                  CH_CR, CH_LF, CH_COMMA, CH_QUOTE, "z", CH_QUOTE};
      send_text();
      drain();

      // Random texts, mostly well formed, with calm stretches and full drains.
      while (items_sent < TARGET_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         if (!wide_done && items_sent > TARGET_ITEMS / 2) begin
            build_wide();
            wide_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            build_noise();
         end else begin
            build_table();
         end
         send_text();
         if ($urandom_range(0, 5) == 0) drain();
      end
      calm = 1'b0;

      // Errors are sticky, so one is raised last and later items must stay silent.
      drain();
      fault = 3'($urandom_range(ERR_EMPTY_HEADER, ERR_UNCLOSED));
      build_fault(fault);
      send_text();
      repeat (3) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("csv_stream_tokenizer_top: match");
      end else begin
         $display("csv_stream_tokenizer_top: mismatch");
      end
      $finish;
   end

endmodule
